// ----- rtl/core/sac_pkg.sv -----
// Shared types and constants of the set-top adapter command responder.
package sac_pkg;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_CHANNEL = 3'd1,
		PH_SEGMENT = 3'd2,
		PH_GETSTAT = 3'd3,
		PH_SETSTAT = 3'd4,
		PH_SEND    = 3'd5
	} phase_t;

	localparam logic [7:0] CMD_CHANNEL = 8'h85;
	localparam logic [7:0] CMD_SEGMENT = 8'h84;
	localparam logic [7:0] CMD_ACK     = 8'h83;
	localparam logic [7:0] CMD_GETSTAT = 8'h82;
	localparam logic [7:0] CMD_SETSTAT = 8'h81;

	localparam logic [7:0] BYTE_ESC     = 8'h10;
	localparam logic [7:0] BYTE_ACK     = 8'h06;
	localparam logic [7:0] BYTE_DONE    = 8'hE4;
	localparam logic [7:0] BYTE_FOUND   = 8'h91;
	localparam logic [7:0] BYTE_MISSING = 8'h90;
	localparam logic [7:0] BYTE_PROMPT  = 8'h9F;
	localparam logic [7:0] BYTE_NOPROMPT = 8'h1F;
	localparam logic [7:0] BYTE_STATEND = 8'hE1;
	localparam logic [7:0] BYTE_STATREQ = 8'h01;

	localparam logic [23:0] TIME_SEGMENT = 24'h7FFFFF;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       segment_found;
		logic       segment_ready;
	} sac_in_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        start_stream;
		logic [7:0]  pkt_num;
		logic [23:0] seg_key;
		logic [15:0] channel;
		logic        last;
	} sac_out_t;

	// outcome of one received byte
	typedef struct packed {
		logic [1:0]      n;
		logic [2:0][7:0] bytes;
		logic            start;
		logic [7:0]      pkt;
		logic [23:0]     seg;
		logic [15:0]     chan;
	} sac_res_t;

endpackage

// ----- rtl/core/sac_if.sv -----
// Valid/ready channels carrying received bytes and responder words.
interface sac_in_if;
	import sac_pkg::*;
	logic    valid;
	logic    ready;
	sac_in_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sac_out_if;
	import sac_pkg::*;
	logic     valid;
	logic     ready;
	sac_out_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/sac_cmd.sv -----
// Command handshake state and per-byte response logic.
module sac_cmd (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  sac_pkg::sac_in_t  item,
	input  logic              prompt,
	output sac_pkg::sac_res_t res
);
	import sac_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [15:0] chan_q, chan_d;
	logic [7:0]  pkt_q, pkt_d;
	logic [23:0] gid_q, gid_d;
	logic [23:0] aid_q, aid_d;
	logic [23:0] gid_full;
	logic        seg_hit;
	logic [7:0]  b;

	assign b        = item.rx_byte;
	assign gid_full = {b, gid_q[15:0]};
	assign seg_hit  = item.segment_found || (gid_full == TIME_SEGMENT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= 2'd0;
			chan_q  <= 16'd0;
			pkt_q   <= 8'd0;
			gid_q   <= 24'd0;
			aid_q   <= 24'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			chan_q  <= chan_d;
			pkt_q   <= pkt_d;
			gid_q   <= gid_d;
			aid_q   <= aid_d;
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q + 2'd1;
		chan_d  = chan_q;
		pkt_d   = pkt_q;
		gid_d   = gid_q;
		aid_d   = aid_q;
		unique case (phase_q)
			PH_CHANNEL: begin
				if (cnt_q == 2'd0) begin
					chan_d = {chan_q[15:8], b};
				end else if (cnt_q == 2'd1) begin
					chan_d  = {b, chan_q[7:0]};
					phase_d = PH_IDLE;
				end
			end
			PH_SEGMENT: begin
				case (cnt_q)
					2'd0: pkt_d = b;
					2'd1: gid_d = {gid_q[23:8], b};
					2'd2: gid_d = {gid_q[23:16], b, gid_q[7:0]};
					default: begin
						gid_d = gid_full;
						if (seg_hit) begin
							phase_d = PH_SEND;
							aid_d   = gid_full;
						end else begin
							phase_d = PH_IDLE;
							aid_d   = 24'd0;
						end
					end
				endcase
			end
			PH_GETSTAT: begin
				cnt_d   = cnt_q;
				phase_d = PH_IDLE;
			end
			PH_SETSTAT: begin
				if (cnt_q == 2'd1)
					phase_d = PH_IDLE;
			end
			PH_SEND: begin
				if (cnt_q == 2'd0) begin
					if (b != BYTE_ESC) begin
						phase_d = PH_IDLE;
						cnt_d   = 2'd0;
					end
				end else if (cnt_q == 2'd1) begin
					phase_d = PH_IDLE;
					if (b != BYTE_ACK)
						cnt_d = 2'd0;
				end
			end
			default: begin
				cnt_d = 2'd0;
				case (b)
					CMD_CHANNEL: phase_d = PH_CHANNEL;
					CMD_SEGMENT: phase_d = PH_SEGMENT;
					CMD_GETSTAT: phase_d = PH_GETSTAT;
					CMD_SETSTAT: phase_d = PH_SETSTAT;
					default:     phase_d = PH_IDLE;
				endcase
			end
		endcase
	end

	// response words
	always_comb begin
		res       = '0;
		res.pkt   = pkt_d;
		res.seg   = aid_d;
		res.chan  = chan_d;
		unique case (phase_q)
			PH_CHANNEL: begin
				if (cnt_q == 2'd1) begin
					res.n        = 2'd1;
					res.bytes[0] = BYTE_DONE;
				end
			end
			PH_SEGMENT: begin
				if (cnt_q == 2'd3) begin
					res.n        = 2'd2;
					res.bytes[0] = BYTE_DONE;
					res.bytes[1] = seg_hit ? BYTE_FOUND : BYTE_MISSING;
				end
			end
			PH_GETSTAT: begin
				if (b == BYTE_STATREQ) begin
					res.n        = 2'd3;
					res.bytes[0] = prompt ? BYTE_PROMPT : BYTE_NOPROMPT;
					res.bytes[1] = BYTE_ESC;
					res.bytes[2] = BYTE_STATEND;
				end else begin
					res.n        = 2'd2;
					res.bytes[0] = BYTE_ESC;
					res.bytes[1] = BYTE_STATEND;
				end
			end
			PH_SETSTAT: begin
				if (cnt_q == 2'd1) begin
					res.n        = 2'd1;
					res.bytes[0] = BYTE_DONE;
				end
			end
			PH_SEND: begin
				if (cnt_q == 2'd1 && b == BYTE_ACK) begin
					if (item.segment_ready) begin
						res.n     = 2'd1;
						res.start = 1'b1;
					end else begin
						res.n        = 2'd3;
						res.bytes[0] = BYTE_ESC;
						res.bytes[1] = BYTE_ACK;
						res.bytes[2] = BYTE_DONE;
					end
				end
			end
			default: begin
				case (b) inside
					CMD_CHANNEL, CMD_SEGMENT, CMD_GETSTAT, CMD_SETSTAT: begin
						res.n        = 2'd2;
						res.bytes[0] = BYTE_ESC;
						res.bytes[1] = BYTE_ACK;
					end
					CMD_ACK: begin
						res.n        = 2'd3;
						res.bytes[0] = BYTE_ESC;
						res.bytes[1] = BYTE_ACK;
						res.bytes[2] = BYTE_DONE;
					end
					default: res.n = 2'd0;
				endcase
			end
		endcase
	end

endmodule

// ----- rtl/core/settop_adapter_command_responder_top.sv -----
// Top level of the set-top adapter command responder.
//
//  channel  dir  handshake      word
//  req      in   valid/ready    rx_byte, segment_found, segment_ready
//  rsp      out  valid/ready    tx_valid, tx_byte, start_stream, pkt_num,
//                               seg_key, channel, last
//  cfg      in   cfg_we         cfg_wdata -> prompt_for_channel
//
// A byte is registered on acceptance and decoded in the following cycle; once the
// result buffer is free, an edge loads its words into it and the first is offered.
// Each byte gives 0 to 3 words, one per cycle while rsp does not stall, and holds
// the buffer until its last word, if any, is taken.
// A new byte is taken while the previous one's last word is being taken.
// arst_n clears the handshake state, phase and gathered registers.
// A stall on rsp holds the buffer and then the input register.
module settop_adapter_command_responder_top (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	sac_in_if.sink    req,
	sac_out_if.source rsp
);
	import sac_pkg::*;

	logic       prompt_q;
	logic       valid_s1;
	sac_in_t    item_s1;
	sac_res_t   res;
	sac_res_t   res_q;
	logic [1:0] n_q;
	logic [1:0] pos_q;
	logic       last;
	logic       fire;
	logic       buf_free;
	logic       advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prompt_q <= 1'b0;
		else if (cfg_we)
			prompt_q <= cfg_wdata;
	end

	assign last     = (pos_q == (n_q - 2'd1));
	assign fire     = rsp.valid && rsp.ready;
	assign buf_free = (n_q == 2'd0) || (fire && last);
	assign advance  = valid_s1 && buf_free;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req.ready)
			valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			item_s1 <= req.payload;
	end

	sac_cmd u_cmd (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.prompt  (prompt_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= 2'd0;
			pos_q <= 2'd0;
		end else if (advance) begin
			n_q   <= res.n;
			pos_q <= 2'd0;
		end else if (fire && last) begin
			n_q <= 2'd0;
		end else if (fire) begin
			pos_q <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign rsp.valid                 = (n_q != 2'd0);
	assign rsp.payload.tx_valid      = !res_q.start;
	assign rsp.payload.tx_byte       = res_q.start ? 8'd0 : res_q.bytes[pos_q];
	assign rsp.payload.start_stream  = res_q.start;
	assign rsp.payload.pkt_num       = res_q.pkt;
	assign rsp.payload.seg_key       = res_q.seg;
	assign rsp.payload.channel       = res_q.chan;
	assign rsp.payload.last          = last;

	a_start_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.start_stream |-> rsp.payload.last && !rsp.payload.tx_valid)
		else $error("stream start not a lone word");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> pos_q < n_q)
		else $error("word index beyond count");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("pending byte lost");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !rsp.valid || (fire && last))
		else $error("result buffer overwritten");

endmodule
